FILE: design/rgss_pkg.sv
// ----------------------------------------------------------------------------
// rgss_pkg: shared definitions for the grid ray setup block
// Fixed-point widths, polynomial coefficients, CSR indices, divider cell and sign types.
// ----------------------------------------------------------------------------
package rgss_pkg;

   localparam int MAP_BITS      = 8;
   localparam int POS_FRAC_BITS = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int DIR_FRAC_BITS = 14;

   // Divisor is a direction magnitude up to 1.0 in Q1.14.
   localparam int DIV_W   = DIR_FRAC_BITS + 1;
   // Quotient of 2^(16+D) by a magnitude of at least one.
   localparam int QUO_W   = 16 + DIR_FRAC_BITS + 1;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   localparam logic [30:0] SIN_C0 = 31'd1686629713;
   localparam logic [30:0] SIN_C1 = 31'd693598668;
   localparam logic [30:0] SIN_C2 = 31'd85569306;
   localparam logic [30:0] SIN_C3 = 31'd5026995;
   localparam logic [30:0] SIN_C4 = 31'd172272;

   // Magnitudes below 0.00001 in Q30 are forced to zero.
   localparam logic [31:0] SIN_ZERO_LIMIT = 32'd10738;
   localparam logic [DIV_W-1:0] DIR_ONE = DIV_W'(1 << DIR_FRAC_BITS);

   // Sine pipeline depth in registers.
   localparam int SINE_LAT = 7;

   typedef enum logic [1:0] {
      CSR_POS_X   = 2'd0,
      CSR_POS_Y   = 2'd1,
      CSR_HEADING = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIV_W-1:0] divisor;
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_cell_type;

   typedef struct packed {
      logic cneg;
      logic sneg;
   } sign_type;

endpackage

FILE: design/rgss_sine.sv
// ----------------------------------------------------------------------------
// rgss_sine: pipelined quarter-wave sine
// Odd polynomial in Q30 with truncating multiplies, then rounding to Q1.14.
// ----------------------------------------------------------------------------
module rgss_sine (
   input  logic        clock,
   input  logic [30:0] x,
   output logic [rgss_pkg::DIV_W-1:0] mag
);

   logic [30:0] x_ff [0:4];
   logic [30:0] x2_ff [0:3];
   logic [30:0] p_ff [0:3];
   logic [31:0] r_ff;
   logic [rgss_pkg::DIV_W-1:0] mag_ff;

   logic [61:0] sq_in;
   logic [61:0] m_in [0:3];
   logic [61:0] r_in;
   logic [31:0] rnd_in;
   logic [rgss_pkg::DIV_W-1:0] mag_in;

   always_comb begin
      sq_in   = {31'h0, x} * {31'h0, x};
      m_in[0] = {31'h0, rgss_pkg::SIN_C4} * {31'h0, x2_ff[0]};
      m_in[1] = {31'h0, p_ff[0]} * {31'h0, x2_ff[1]};
      m_in[2] = {31'h0, p_ff[1]} * {31'h0, x2_ff[2]};
      m_in[3] = {31'h0, p_ff[2]} * {31'h0, x2_ff[3]};
      r_in    = {31'h0, p_ff[3]} * {31'h0, x_ff[4]};
      rnd_in  = (r_ff + 32'h0000_8000) >> 16;
      if (r_ff < rgss_pkg::SIN_ZERO_LIMIT) begin
         mag_in = '0;
      end else if (rnd_in > {17'h0, rgss_pkg::DIR_ONE}) begin
         mag_in = rgss_pkg::DIR_ONE;
      end else begin
         mag_in = rnd_in[rgss_pkg::DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]  <= x;
      x2_ff[0] <= sq_in[60:30];
      for (int i = 1; i < 5; i++) x_ff[i] <= x_ff[i-1];
      for (int i = 1; i < 4; i++) x2_ff[i] <= x2_ff[i-1];
      p_ff[0] <= rgss_pkg::SIN_C3 - m_in[0][60:30];
      p_ff[1] <= rgss_pkg::SIN_C2 - m_in[1][60:30];
      p_ff[2] <= rgss_pkg::SIN_C1 - m_in[2][60:30];
      p_ff[3] <= rgss_pkg::SIN_C0 - m_in[3][60:30];
      r_ff    <= r_in[61:30];
      mag_ff  <= mag_in;
   end

   assign mag = mag_ff;

endmodule

FILE: design/rgss_div_cell.sv
// ----------------------------------------------------------------------------
// rgss_div_cell: one restoring division step
// Shifts in one dividend bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module rgss_div_cell (
   input  logic                   clock,
   input  logic                   dividend_bit,
   input  rgss_pkg::div_cell_type cell_in,
   output rgss_pkg::div_cell_type cell_out
);

   rgss_pkg::div_cell_type cell_ff;
   rgss_pkg::div_cell_type cell_in_next;
   logic [rgss_pkg::DIV_W:0] trial;
   logic fits;

   always_comb begin
      trial = {cell_in.rem, dividend_bit};
      fits  = trial >= {1'b0, cell_in.divisor};
      cell_in_next.divisor = cell_in.divisor;
      if (fits) begin
         cell_in_next.rem = rgss_pkg::DIV_W'(trial - {1'b0, cell_in.divisor});
      end else begin
         cell_in_next.rem = trial[rgss_pkg::DIV_W-1:0];
      end
      cell_in_next.quo = {cell_in.quo[rgss_pkg::QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_next;
   end

   assign cell_out = cell_ff;

endmodule

FILE: design/rgss_divider.sv
// ----------------------------------------------------------------------------
// rgss_divider: row of division cells
// Divides 2^(16+D) by the divisor, one quotient bit per cell and cycle.
// ----------------------------------------------------------------------------
module rgss_divider (
   input  logic                        clock,
   input  logic [rgss_pkg::DIV_W-1:0]  divisor,
   output logic [rgss_pkg::DIV_W-1:0]  divisor_out,
   output logic [rgss_pkg::QUO_W-1:0]  quotient
);

   rgss_pkg::div_cell_type chain [0:rgss_pkg::DIV_STEPS];

   assign chain[0].divisor = divisor;
   assign chain[0].rem     = '0;
   assign chain[0].quo     = '0;

   // The dividend is a single one at its top bit.
   for (genvar k = 0; k < rgss_pkg::DIV_STEPS; k++) begin : g_cell
      rgss_div_cell u_cell (
         .clock        (clock),
         .dividend_bit (k == 0),
         .cell_in      (chain[k]),
         .cell_out     (chain[k+1])
      );
   end

   assign divisor_out = chain[rgss_pkg::DIV_STEPS].divisor;
   assign quotient    = chain[rgss_pkg::DIV_STEPS].quo;

endmodule

FILE: design/ray_grid_step_setup.sv
// ----------------------------------------------------------------------------
// ray_grid_step_setup: per-ray setup for a grid walking raycaster
// Direction, start cell, step signs, grid line spacing and first distances.
// ----------------------------------------------------------------------------
// Usage
//   Write the viewer position (pos_x, pos_y, Q8.16) and heading through the
//   csr_ port while the block is idle; a write takes effect at once.
//   An item is one ray angle offset on req_ray_offset, taken at a clock edge
//   where start is high and busy is low. busy is high during reset and in the
//   cycle after it, so from then on a new item may be presented every cycle.
//   Each item yields exactly one result, shown on the rsp_ ports for one
//   cycle with rsp_valid high. Results leave in the order the items came
//   in. Throughput is one item per cycle. The result passes through the
//   angle register, the pipelined sine polynomial, quadrant selection,
//   the row of 31 division cells that forms the reciprocal one quotient
//   bit per cell, the side distance multiply and the output register.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Reset clears the configuration registers and drops every item in flight.
// ----------------------------------------------------------------------------
module ray_grid_step_setup (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_ray_offset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data,
   output logic        rsp_valid,
   output logic [15:0] rsp_dir_x,
   output logic [15:0] rsp_dir_y,
   output logic [7:0]  rsp_cell_x,
   output logic [7:0]  rsp_cell_y,
   output logic        rsp_step_x_negative,
   output logic        rsp_step_y_negative,
   output logic [31:0] rsp_delta_x,
   output logic [31:0] rsp_delta_y,
   output logic [31:0] rsp_side_dist_x,
   output logic [31:0] rsp_side_dist_y
);

   localparam int SEL_ST  = 1 + rgss_pkg::SINE_LAT;
   localparam int DIV_END = SEL_ST + rgss_pkg::DIV_STEPS;
   localparam int LAT     = DIV_END + 3;

   // Configuration registers.
   logic [23:0] pos_x_ff;
   logic [23:0] pos_y_ff;
   logic [15:0] heading_ff;
   logic        busy_ff;

   // Valid bit for every pipeline stage.
   logic [LAT-1:0] vld_ff;

   logic [15:0] angle_ff;
   logic [1:0]  quad_ff [0:rgss_pkg::SINE_LAT-1];
   logic [30:0] sin_arg0;
   logic [30:0] sin_arg1;
   logic [rgss_pkg::DIV_W-1:0] mag0;
   logic [rgss_pkg::DIV_W-1:0] mag1;

   // Quadrant selection stage.
   logic [rgss_pkg::DIV_W-1:0] cmag_ff, cmag_in;
   logic [rgss_pkg::DIV_W-1:0] smag_ff, smag_in;
   rgss_pkg::sign_type sign_ff, sign_in;
   rgss_pkg::sign_type sign_dly_ff [0:rgss_pkg::DIV_STEPS-1];

   // Divider outputs.
   logic [rgss_pkg::DIV_W-1:0] cmag_div, smag_div;
   logic [rgss_pkg::QUO_W-1:0] quo_x, quo_y;

   // Product stage.
   logic [rgss_pkg::POS_FRAC_BITS:0] frac_x, frac_y;
   logic [rgss_pkg::POS_FRAC_BITS:0] f_x, f_y;
   logic [47:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [rgss_pkg::DIV_W-1:0] cmag_p_ff, smag_p_ff;
   logic [rgss_pkg::QUO_W-1:0] quo_x_ff, quo_y_ff;
   rgss_pkg::sign_type sign_p_ff;

   // Output registers.
   logic [15:0] dir_x_ff, dir_y_ff;
   logic        stepx_ff, stepy_ff;
   logic [31:0] delta_x_ff, delta_y_ff, side_x_ff, side_y_ff;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         heading_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rgss_pkg::CSR_POS_X:   pos_x_ff   <= csr_write_data;
            rgss_pkg::CSR_POS_Y:   pos_y_ff   <= csr_write_data;
            rgss_pkg::CSR_HEADING: heading_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[LAT-2:0], start & ~busy_ff};
      end
   end

   assign busy = busy_ff;

   // The angle wraps naturally in 16 bits.
   always_ff @(posedge clock) begin
      angle_ff <= heading_ff + req_ray_offset;
   end

   // Fraction within the quarter turn, and its complement, in Q30.
   assign sin_arg0 = {1'b0, angle_ff[13:0], 16'h0};
   assign sin_arg1 = rgss_pkg::Q30_ONE - sin_arg0;

   rgss_sine u_sine0 (.clock(clock), .x(sin_arg0), .mag(mag0));
   rgss_sine u_sine1 (.clock(clock), .x(sin_arg1), .mag(mag1));

   always_ff @(posedge clock) begin
      quad_ff[0] <= angle_ff[15:14];
      for (int i = 1; i < rgss_pkg::SINE_LAT; i++) quad_ff[i] <= quad_ff[i-1];
   end

   // Map the quarter-wave values onto cosine and sine by quadrant. A
   // component that came out as zero never counts as negative.
   always_comb begin
      case (quad_ff[rgss_pkg::SINE_LAT-1])
         2'd0: begin
            smag_in = mag0; cmag_in = mag1; sign_in.sneg = 1'b0; sign_in.cneg = 1'b0;
         end
         2'd1: begin
            smag_in = mag1; cmag_in = mag0; sign_in.sneg = 1'b0; sign_in.cneg = 1'b1;
         end
         2'd2: begin
            smag_in = mag0; cmag_in = mag1; sign_in.sneg = 1'b1; sign_in.cneg = 1'b1;
         end
         default: begin
            smag_in = mag1; cmag_in = mag0; sign_in.sneg = 1'b1; sign_in.cneg = 1'b0;
         end
      endcase
      if (cmag_in == '0) sign_in.cneg = 1'b0;
      if (smag_in == '0) sign_in.sneg = 1'b0;
   end

   always_ff @(posedge clock) begin
      cmag_ff <= cmag_in;
      smag_ff <= smag_in;
      sign_ff <= sign_in;
      sign_dly_ff[0] <= sign_ff;
      for (int i = 1; i < rgss_pkg::DIV_STEPS; i++) sign_dly_ff[i] <= sign_dly_ff[i-1];
   end

   rgss_divider u_div_x (
      .clock(clock), .divisor(cmag_ff), .divisor_out(cmag_div), .quotient(quo_x)
   );
   rgss_divider u_div_y (
      .clock(clock), .divisor(smag_ff), .divisor_out(smag_div), .quotient(quo_y)
   );

   // Distance to the first grid line scales the spacing by the fraction of
   // a cell still to cover. The product stays well inside 32 bits after the
   // shift, since the fraction is at most one and the spacing below 2^31.
   assign frac_x = {1'b0, pos_x_ff[rgss_pkg::POS_FRAC_BITS-1:0]};
   assign frac_y = {1'b0, pos_y_ff[rgss_pkg::POS_FRAC_BITS-1:0]};
   assign f_x = sign_dly_ff[rgss_pkg::DIV_STEPS-1].cneg ? frac_x : 17'h10000 - frac_x;
   assign f_y = sign_dly_ff[rgss_pkg::DIV_STEPS-1].sneg ? frac_y : 17'h10000 - frac_y;
   assign prod_x_in = {31'h0, f_x} * {17'h0, quo_x};
   assign prod_y_in = {31'h0, f_y} * {17'h0, quo_y};

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      quo_x_ff  <= quo_x;
      quo_y_ff  <= quo_y;
      cmag_p_ff <= cmag_div;
      smag_p_ff <= smag_div;
      sign_p_ff <= sign_dly_ff[rgss_pkg::DIV_STEPS-1];
   end

   // A zero component means the ray never crosses that axis's grid lines.
   always_ff @(posedge clock) begin
      dir_x_ff <= sign_p_ff.cneg ? 16'(-{1'b0, cmag_p_ff}) : {1'b0, cmag_p_ff};
      dir_y_ff <= sign_p_ff.sneg ? 16'(-{1'b0, smag_p_ff}) : {1'b0, smag_p_ff};
      stepx_ff <= sign_p_ff.cneg;
      stepy_ff <= sign_p_ff.sneg;
      if (cmag_p_ff == '0) begin
         delta_x_ff <= '1;
         side_x_ff  <= '1;
      end else begin
         delta_x_ff <= {1'b0, quo_x_ff};
         side_x_ff  <= prod_x_ff[47:16];
      end
      if (smag_p_ff == '0) begin
         delta_y_ff <= '1;
         side_y_ff  <= '1;
      end else begin
         delta_y_ff <= {1'b0, quo_y_ff};
         side_y_ff  <= prod_y_ff[47:16];
      end
   end

   assign rsp_valid           = vld_ff[LAT-1];
   assign rsp_dir_x           = dir_x_ff;
   assign rsp_dir_y           = dir_y_ff;
   assign rsp_cell_x          = pos_x_ff[23:16];
   assign rsp_cell_y          = pos_y_ff[23:16];
   assign rsp_step_x_negative = stepx_ff;
   assign rsp_step_y_negative = stepy_ff;
   assign rsp_delta_x         = delta_x_ff;
   assign rsp_delta_y         = delta_y_ff;
   assign rsp_side_dist_x     = side_x_ff;
   assign rsp_side_dist_y     = side_y_ff;

   // A negative x step always goes with a negative x direction component.
   a_step_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_x_negative |-> rsp_dir_x[15])
      else $error("step sign without negative x direction");

   // Infinite y spacing exactly when the y component is zero.
   a_zero_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_dir_y == 16'h0) == (rsp_delta_y == 32'hFFFF_FFFF)))
      else $error("y spacing and direction disagree on zero");

   // The first crossing is never further than one full spacing.
   a_side_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_side_dist_x <= rsp_delta_x) && (rsp_side_dist_y <= rsp_delta_y))
      else $error("side distance beyond grid spacing");

   // No result appears unless the valid bit of the stage before it was set.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[LAT-2]))
      else $error("result without a matching item");

endmodule

FILE: dv/ray_grid_step_setup_test.sv
// ----------------------------------------------------------------------------
// ray_grid_step_setup_test: self-checking bench for the grid ray setup block
// Rays are sent under several viewer positions and headings. A bit-true
// model predicts each ray's setup, and every result is compared field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_grid_step_setup_test;

   // One predicted ray setup, in the order of the result ports.
   typedef struct {
      logic [15:0] dir_x;
      logic [15:0] dir_y;
      logic [7:0]  cell_x;
      logic [7:0]  cell_y;
      logic        step_x_negative;
      logic        step_y_negative;
      logic [31:0] delta_x;
      logic [31:0] delta_y;
      logic [31:0] side_dist_x;
      logic [31:0] side_dist_y;
   } ray_setup_type;

   // The watchdog limit is far above the block's pipeline depth, so the margin is generous.
   localparam int PIPE_LATENCY = 42;
   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_ray_offset = '0;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_write_data = '0;
   logic        rsp_valid;
   logic [15:0] rsp_dir_x;
   logic [15:0] rsp_dir_y;
   logic [7:0]  rsp_cell_x;
   logic [7:0]  rsp_cell_y;
   logic        rsp_step_x_negative;
   logic        rsp_step_y_negative;
   logic [31:0] rsp_delta_x;
   logic [31:0] rsp_delta_y;
   logic [31:0] rsp_side_dist_x;
   logic [31:0] rsp_side_dist_y;

   // The bench keeps its own copy of the configuration registers.
   logic [23:0] view_pos_x = '0;
   logic [23:0] view_pos_y = '0;
   logic [15:0] view_heading = '0;

   ray_setup_type pending_setups[$];
   int  error_count = 0;
   int  idle_cycles = 0;

   always #5 clock = ~clock;

   ray_grid_step_setup u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_ray_offset      (req_ray_offset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_dir_x           (rsp_dir_x),
      .rsp_dir_y           (rsp_dir_y),
      .rsp_cell_x          (rsp_cell_x),
      .rsp_cell_y          (rsp_cell_y),
      .rsp_step_x_negative (rsp_step_x_negative),
      .rsp_step_y_negative (rsp_step_y_negative),
      .rsp_delta_x         (rsp_delta_x),
      .rsp_delta_y         (rsp_delta_y),
      .rsp_side_dist_x     (rsp_side_dist_x),
      .rsp_side_dist_y     (rsp_side_dist_y)
   );

   // Odd polynomial for sin(pi/2 * x) with x in Q30, truncating multiplies.
   function automatic logic [63:0] quarter_wave_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] p;
      x2 = (x * x) >> 30;
      p = 64'(rgss_pkg::SIN_C4);
      p = 64'(rgss_pkg::SIN_C3) - ((p * x2) >> 30);
      p = 64'(rgss_pkg::SIN_C2) - ((p * x2) >> 30);
      p = 64'(rgss_pkg::SIN_C1) - ((p * x2) >> 30);
      p = 64'(rgss_pkg::SIN_C0) - ((p * x2) >> 30);
      return (p * x) >> 30;
   endfunction

   // Q30 magnitude to a direction magnitude: tiny values become zero, the rest
   // are rounded half up and held at no more than one.
   function automatic logic [63:0] direction_magnitude(input logic [63:0] v);
      logic [63:0] r;
      if (v * 64'd100000 < 64'h4000_0000) return 64'd0;
      r = (v + (64'd1 << (29 - rgss_pkg::DIR_FRAC_BITS))) >> (30 - rgss_pkg::DIR_FRAC_BITS);
      if (r > (64'd1 << rgss_pkg::DIR_FRAC_BITS)) r = 64'd1 << rgss_pkg::DIR_FRAC_BITS;
      return r;
   endfunction

   // Grid line spacing and first distance along one axis.
   function automatic void grid_axis(input logic [23:0] pos, input logic [63:0] mag,
                                     input logic neg, output logic [7:0] map_cell,
                                     output logic [31:0] delta, output logic [31:0] side);
      logic [63:0] frac;
      logic [63:0] span;
      logic [63:0] quot;
      logic [63:0] prod;
      frac = 64'(pos[rgss_pkg::POS_FRAC_BITS-1:0]);
      map_cell = pos[rgss_pkg::POS_FRAC_BITS +: rgss_pkg::MAP_BITS];
      if (mag == 0) begin
         delta = '1;
         side = '1;
      end else begin
         quot = (64'd1 << (16 + rgss_pkg::DIR_FRAC_BITS)) / mag;
         if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
         delta = quot[31:0];
         span = neg ? frac : (64'd1 << rgss_pkg::POS_FRAC_BITS) - frac;
         prod = (span * quot) >> rgss_pkg::POS_FRAC_BITS;
         side = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      end
   endfunction

   function automatic ray_setup_type predict_ray_setup(input logic [15:0] offset);
      ray_setup_type s;
      logic [15:0] angle;
      logic [1:0]  quadrant;
      logic [63:0] x;
      logic [63:0] s0;
      logic [63:0] s1;
      logic [63:0] cmag;
      logic [63:0] smag;
      logic        cneg;
      logic        sneg;
      angle = view_heading + offset;
      quadrant = angle[15:14];
      x = 64'(angle[13:0]) << (32 - rgss_pkg::ANGLE_BITS);
      s0 = direction_magnitude(quarter_wave_sine(x));
      s1 = direction_magnitude(quarter_wave_sine(64'h4000_0000 - x));
      case (quadrant)
         2'd0: begin smag = s0; cmag = s1; sneg = 1'b0; cneg = 1'b0; end
         2'd1: begin smag = s1; cmag = s0; sneg = 1'b0; cneg = 1'b1; end
         2'd2: begin smag = s0; cmag = s1; sneg = 1'b1; cneg = 1'b1; end
         default: begin smag = s1; cmag = s0; sneg = 1'b1; cneg = 1'b0; end
      endcase
      if (cmag == 0) cneg = 1'b0;
      if (smag == 0) sneg = 1'b0;
      grid_axis(view_pos_x, cmag, cneg, s.cell_x, s.delta_x, s.side_dist_x);
      grid_axis(view_pos_y, smag, sneg, s.cell_y, s.delta_y, s.side_dist_y);
      s.dir_x = cneg ? 16'(-cmag) : 16'(cmag);
      s.dir_y = sneg ? 16'(-smag) : 16'(smag);
      s.step_x_negative = cneg;
      s.step_y_negative = sneg;
      return s;
   endfunction

   // Result checker: every strobed result is matched against the oldest
   // prediction. The receiver cannot stall, so there is nothing to drive here.
   always @(posedge clock) begin
      ray_setup_type e;
      if (!reset && rsp_valid) begin
         if (pending_setups.size() == 0) begin
            $error("result arrived with no ray waiting");
            error_count++;
         end else begin
            e = pending_setups.pop_front();
            if (rsp_dir_x !== e.dir_x) begin
               $error("dir_x expected %h actual %h", e.dir_x, rsp_dir_x);
               error_count++;
            end
            if (rsp_dir_y !== e.dir_y) begin
               $error("dir_y expected %h actual %h", e.dir_y, rsp_dir_y);
               error_count++;
            end
            if (rsp_cell_x !== e.cell_x) begin
               $error("cell_x expected %h actual %h", e.cell_x, rsp_cell_x);
               error_count++;
            end
            if (rsp_cell_y !== e.cell_y) begin
               $error("cell_y expected %h actual %h", e.cell_y, rsp_cell_y);
               error_count++;
            end
            if (rsp_step_x_negative !== e.step_x_negative) begin
               $error("step_x_negative expected %b actual %b",
                      e.step_x_negative, rsp_step_x_negative);
               error_count++;
            end
            if (rsp_step_y_negative !== e.step_y_negative) begin
               $error("step_y_negative expected %b actual %b",
                      e.step_y_negative, rsp_step_y_negative);
               error_count++;
            end
            if (rsp_delta_x !== e.delta_x) begin
               $error("delta_x expected %h actual %h", e.delta_x, rsp_delta_x);
               error_count++;
            end
            if (rsp_delta_y !== e.delta_y) begin
               $error("delta_y expected %h actual %h", e.delta_y, rsp_delta_y);
               error_count++;
            end
            if (rsp_side_dist_x !== e.side_dist_x) begin
               $error("side_dist_x expected %h actual %h",
                      e.side_dist_x, rsp_side_dist_x);
               error_count++;
            end
            if (rsp_side_dist_y !== e.side_dist_y) begin
               $error("side_dist_y expected %h actual %h",
                      e.side_dist_y, rsp_side_dist_y);
               error_count++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one, and often none at all.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Sends one ray. start stays high across back-to-back items, so it is
   // only lowered when a gap follows.
   task automatic send_ray(input logic [15:0] offset, input int gap);
      start <= 1'b1;
      req_ray_offset <= offset;
      do @(posedge clock); while (busy);
      pending_setups.push_back(predict_ray_setup(offset));
      if (gap > 0) begin
         start <= 1'b0;
         req_ray_offset <= 16'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Register write, only while nothing is in flight. The write enable is
   // left high so that writes can follow one another; the caller lowers it.
   task automatic write_register(input rgss_pkg::csr_index_type idx,
                                 input logic [23:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         rgss_pkg::CSR_POS_X:   view_pos_x = value;
         rgss_pkg::CSR_POS_Y:   view_pos_y = value;
         rgss_pkg::CSR_HEADING: view_heading = value[15:0];
         default: ;
      endcase
   endtask

   // Lets the pipeline drain before the configuration changes.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (pending_setups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_view(input logic [23:0] px, input logic [23:0] py,
                           input logic [15:0] hd);
      drain_pipeline();
      write_register(rgss_pkg::CSR_POS_X, px);
      write_register(rgss_pkg::CSR_POS_Y, py);
      write_register(rgss_pkg::CSR_HEADING, {8'h00, hd});
      csr_write_enable <= 1'b0;
   endtask

   // Axis-aligned rays give exact zero components (infinite deltas), the
   // offset extremes test the angle wrap, and the neighbours of each axis
   // test the smallest nonzero components.
   task automatic test_directed_rays();
      logic [15:0] offsets[20];
      offsets = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8001,
                  16'h0001, 16'hFFFF, 16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001,
                  16'h2000, 16'h6000, 16'hA000, 16'hE000, 16'h5555, 16'hAAAA,
                  16'h1234, 16'hEDCB};
      set_view(24'h000000, 24'h000000, 16'h0000);
      foreach (offsets[i]) send_ray(offsets[i], gap_length());
      set_view(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
      foreach (offsets[i]) if (i < 5) send_ray(offsets[i], 0);
   endtask

   // Random rays in several random views; positions near a grid line push
   // the side distances to both ends.
   task automatic test_random_rays();
      logic [23:0] px;
      logic [23:0] py;
      for (int phase = 0; phase < 8; phase++) begin
         px = 24'($urandom);
         py = 24'($urandom);
         if (phase == 1) px[15:0] = 16'h0000;
         if (phase == 2) py[15:0] = 16'hFFFF;
         set_view(px, py, 16'($urandom));
         for (int n = 0; n < 115; n++) begin
            if ($urandom_range(0, 9) == 0)
               send_ray(16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 2)) - 16'd1,
                        gap_length());
            else
               send_ray(16'($urandom), ($urandom_range(0, 3) == 0) ? 0 : gap_length());
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_rays();
      test_random_rays();
      drain_pipeline();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_setups.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
